### hw/rtl/regression_slope_trend_top_macros.svh
// Assertion macros shared by the regression slope trend RTL.
`ifndef REGRESSION_SLOPE_TREND_TOP_MACROS_SVH
`define REGRESSION_SLOPE_TREND_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define RST_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define RST_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/rst_pkg.sv
// Package: widths, codes and types of the regression slope trend block.
`default_nettype none
package rst_pkg;

	localparam int unsigned MAX_SAMPLES_DEF = 1024;
	localparam int unsigned MIN_SAMPLES     = 3;

	localparam int unsigned TIME_W     = 32;
	localparam int unsigned VALUE_W    = 24;
	localparam int unsigned REL_W      = 24;
	localparam int unsigned SLOPE_W    = 40;
	localparam int unsigned TREND_W    = 2;
	localparam int unsigned DIR_W      = 2;
	localparam int unsigned SENS_W     = 31;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 31;

	localparam int unsigned SUM_W   = 34;
	localparam int unsigned PSUM_W  = 58;
	localparam int unsigned QSUM_W  = 57;
	localparam int unsigned OPND_W  = 33;
	localparam int unsigned PROD_W  = 2 * OPND_W;
	localparam int unsigned CHUNK_W = 32;
	localparam int unsigned MAG_W   = 2 * CHUNK_W;
	localparam int unsigned ACC_W   = 72;
	localparam int unsigned STEP_W  = 4;

	localparam logic signed [TIME_W:0] REL_MAX_X = 33'sd8388607;
	localparam logic signed [TIME_W:0] REL_MIN_X = -33'sd8388608;
	localparam logic signed [REL_W-1:0] REL_MAX = 24'sh7FFFFF;
	localparam logic signed [REL_W-1:0] REL_MIN = 24'sh800000;

	localparam logic [SLOPE_W-1:0] SLOPE_POS_MAX = 40'h7F_FFFF_FFFF;
	localparam logic [SLOPE_W-1:0] SLOPE_NEG_MAG = 40'h80_0000_0000;

	localparam logic [TREND_W-1:0] TREND_STABLE    = 2'd0;
	localparam logic [TREND_W-1:0] TREND_IMPROVING = 2'd1;
	localparam logic [TREND_W-1:0] TREND_WORSE     = 2'd2;
	localparam logic [TREND_W-1:0] TREND_UNDEF     = 2'd3;

	localparam logic [DIR_W-1:0] DIR_LOWER = 2'd1;

	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = 1'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TY,
		ST_TT,
		ST_CHECK,
		ST_MUL,
		ST_ACC,
		ST_DIV,
		ST_CAP,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic signed [OPND_W-1:0] a;
		logic signed [OPND_W-1:0] b;
	} mul_op_t;

endpackage
`default_nettype wire

### hw/rtl/regression_slope_trend_top.sv
// Top level: least-squares slope and trend over one window of samples.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-----------------------------------
//  sample   | sample_valid / sample_stall | sample_time, sample_value, window_end
//  result   | result_valid / result_stall | slope, trend, overflowed
//  config   | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
//  A sample makes the transfer, then two passes of the shared multiplier, while
//  sample_stall is high. Closing a window of 3 or more samples runs the partial
//  products on the multiplier, then the bit-serial divider if the denominator is
//  positive. A short window skips both. Reset clears state, sums and result valid.
//  A waiting result holds in its register; the next window is taken meanwhile,
//  and only its close waits for the result register to empty.
`default_nettype none
`include "regression_slope_trend_top_macros.svh"
module regression_slope_trend_top import rst_pkg::*; #(
	parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         sample_valid,
	output logic                              sample_stall,
	input  wire logic        [TIME_W-1:0]     sample_time,
	input  wire logic signed [VALUE_W-1:0]    sample_value,
	input  wire logic                         window_end,
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output logic signed      [SLOPE_W-1:0]    slope,
	output logic             [TREND_W-1:0]    trend,
	output logic                              overflowed,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic        [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic        [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);

	state_t state_q, state_d;

	logic [DIR_W-1:0]  direction_q;
	logic [SENS_W-1:0] sens_q;

	logic [TIME_W-1:0]        ref_q;
	logic [CNT_W-1:0]         count_q;
	logic signed [SUM_W-1:0]  time_sum_q;
	logic signed [SUM_W-1:0]  value_sum_q;
	logic signed [PSUM_W-1:0] prod_sum_q;
	logic [QSUM_W-1:0]        sq_sum_q;
	logic                     ovf_q;
	logic                     pend_q;
	logic                     last_q;
	logic signed [REL_W-1:0]   rel_q;
	logic signed [VALUE_W-1:0] y_q;

	logic [STEP_W-1:0]  step_q;
	logic [ACC_W-1:0]   acc_q;
	logic [ACC_W-1:0]   num_q;
	logic               den_ok_q;
	logic               und_q;
	logic [MAG_W-1:0]   tmag_q, vmag_q, pmag_q;
	logic               tneg_q, vneg_q, pneg_q;
	logic [SLOPE_W-1:0] mag_q;

	logic                      result_valid_q;
	logic signed [SLOPE_W-1:0] slope_q;
	logic [TREND_W-1:0]        trend_q;
	logic                      ovf_out_q;

	logic                     accept;
	logic                     full;
	logic [TIME_W-1:0]        ref_use;
	logic signed [TIME_W:0]   rel_diff;
	logic signed [REL_W-1:0]  rel_d;
	logic                     rel_out;

	logic [1:0]         prod_idx;
	logic               ja, jb;
	logic [MAG_W-1:0]   a_mag, b_mag;
	logic               a_neg, b_neg;
	logic [CHUNK_W-1:0] a_chunk, b_chunk;
	logic [ACC_W-1:0]   pp_w, pp_sh, acc_nxt;
	logic               acc_sub;
	logic               last_step;
	logic               den_ok_now;

	logic                      mul_en;
	mul_op_t                   mul_op;
	logic signed [PROD_W-1:0]  prod;
	logic                      div_start;
	logic                      div_done;
	logic [ACC_W-1:0]          div_num;
	logic [ACC_W-1:0]          div_quo;

	logic               out_free;
	logic               load_out;
	logic               num_neg;
	logic [ACC_W-1:0]   q_eff;
	logic [SLOPE_W-1:0] cap;
	logic               q_over;
	logic               neg_eff;
	logic [SLOPE_W-1:0] slope_d;
	logic [TREND_W-1:0] trend_d;

	// sample side
	assign accept   = sample_valid && (state_q == ST_IDLE);
	assign full     = count_q >= CNT_W'(MAX_SAMPLES);
	assign ref_use  = (count_q == '0) ? sample_time : ref_q;
	assign rel_diff = $signed({1'b0, sample_time}) - $signed({1'b0, ref_use});
	always_comb begin
		rel_out = 1'b1;
		if (rel_diff > REL_MAX_X) begin
			rel_d = REL_MAX;
		end else if (rel_diff < REL_MIN_X) begin
			rel_d = REL_MIN;
		end else begin
			rel_d   = rel_diff[REL_W-1:0];
			rel_out = 1'b0;
		end
	end

	// closing operand selection
	assign prod_idx  = step_q[3:2];
	assign ja        = step_q[1];
	assign jb        = step_q[0];
	assign last_step = (step_q == '1);
	always_comb begin
		case (prod_idx)
			2'd0: begin
				a_mag = MAG_W'(count_q); a_neg = 1'b0;
				b_mag = pmag_q;          b_neg = pneg_q;
			end
			2'd1: begin
				a_mag = tmag_q; a_neg = tneg_q;
				b_mag = vmag_q; b_neg = vneg_q;
			end
			2'd2: begin
				a_mag = MAG_W'(count_q);  a_neg = 1'b0;
				b_mag = MAG_W'(sq_sum_q); b_neg = 1'b0;
			end
			default: begin
				a_mag = tmag_q; a_neg = tneg_q;
				b_mag = tmag_q; b_neg = tneg_q;
			end
		endcase
	end
	assign a_chunk = ja ? a_mag[MAG_W-1:CHUNK_W] : a_mag[CHUNK_W-1:0];
	assign b_chunk = jb ? b_mag[MAG_W-1:CHUNK_W] : b_mag[CHUNK_W-1:0];

	assign pp_w = ACC_W'(prod[MAG_W-1:0]);
	always_comb begin
		case ({ja, jb})
			2'b00:   pp_sh = pp_w;
			2'b11:   pp_sh = pp_w << (2 * CHUNK_W);
			default: pp_sh = pp_w << CHUNK_W;
		endcase
	end
	assign acc_sub    = a_neg ^ b_neg ^ prod_idx[0];
	assign acc_nxt    = acc_sub ? (acc_q - pp_sh) : (acc_q + pp_sh);
	assign den_ok_now = !acc_nxt[ACC_W-1] && (acc_nxt != '0);

	assign num_neg = num_q[ACC_W-1];
	assign div_num = num_neg ? (~num_q + 1'b1) : num_q;

	// result forming
	assign q_eff   = den_ok_q ? div_quo : '0;
	assign cap     = num_neg ? SLOPE_NEG_MAG : SLOPE_POS_MAX;
	assign q_over  = (q_eff[ACC_W-1:SLOPE_W] != '0) || (q_eff[SLOPE_W-1:0] > cap);
	assign neg_eff = num_neg && (mag_q != '0);
	always_comb begin
		if (und_q) begin
			slope_d = '0;
			trend_d = TREND_UNDEF;
		end else begin
			slope_d = neg_eff ? (~mag_q + 1'b1) : mag_q;
			if (mag_q <= SLOPE_W'(sens_q)) begin
				trend_d = TREND_STABLE;
			end else if (direction_q == DIR_LOWER) begin
				trend_d = neg_eff ? TREND_IMPROVING : TREND_WORSE;
			end else begin
				trend_d = neg_eff ? TREND_WORSE : TREND_IMPROVING;
			end
		end
	end

	assign out_free = !result_valid_q || !result_stall;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mul_en    = 1'b0;
		mul_op.a  = OPND_W'(signed'({1'b0, a_chunk}));
		mul_op.b  = OPND_W'(signed'({1'b0, b_chunk}));
		div_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!full) begin
						state_d = ST_TY;
					end else if (window_end) begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_TY: begin
				mul_en   = 1'b1;
				mul_op.a = OPND_W'(rel_q);
				mul_op.b = OPND_W'(y_q);
				state_d  = ST_TT;
			end
			ST_TT: begin
				mul_en   = 1'b1;
				mul_op.a = OPND_W'(rel_q);
				mul_op.b = OPND_W'(rel_q);
				state_d  = last_q ? ST_CHECK : ST_IDLE;
			end
			ST_CHECK: begin
				state_d = (count_q < CNT_W'(MIN_SAMPLES)) ? ST_FINISH : ST_MUL;
			end
			ST_MUL: begin
				mul_en  = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				if (last_step) begin
					div_start = den_ok_now;
					state_d   = den_ok_now ? ST_DIV : ST_CAP;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_CAP;
				end
			end
			ST_CAP: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= '0;
			sens_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DIRECTION:   direction_q <= cfg_data[DIR_W-1:0];
				REG_SENSITIVITY: sens_q      <= cfg_data[SENS_W-1:0];
				default: ;
			endcase
		end
	end

	// window sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q       <= '0;
			count_q     <= '0;
			time_sum_q  <= '0;
			value_sum_q <= '0;
			prod_sum_q  <= '0;
			sq_sum_q    <= '0;
			ovf_q       <= 1'b0;
			pend_q      <= 1'b0;
		end else if (load_out) begin
			ref_q       <= '0;
			count_q     <= '0;
			time_sum_q  <= '0;
			value_sum_q <= '0;
			prod_sum_q  <= '0;
			sq_sum_q    <= '0;
			ovf_q       <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			if (pend_q) begin
				sq_sum_q <= sq_sum_q + QSUM_W'(prod);
				pend_q   <= 1'b0;
			end
			if (accept) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					ref_q       <= ref_use;
					count_q     <= count_q + 1'b1;
					time_sum_q  <= time_sum_q + SUM_W'(rel_d);
					value_sum_q <= value_sum_q + SUM_W'(sample_value);
					if (rel_out) begin
						ovf_q <= 1'b1;
					end
				end
			end
			if (state_q == ST_TT) begin
				prod_sum_q <= prod_sum_q + PSUM_W'(prod);
				pend_q     <= 1'b1;
			end
		end
	end

	// sample and closing datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			rel_q  <= rel_d;
			y_q    <= sample_value;
			last_q <= window_end;
		end
		case (state_q)
			ST_CHECK: begin
				und_q    <= count_q < CNT_W'(MIN_SAMPLES);
				step_q   <= '0;
				acc_q    <= '0;
				den_ok_q <= 1'b0;
				tneg_q   <= time_sum_q[SUM_W-1];
				vneg_q   <= value_sum_q[SUM_W-1];
				pneg_q   <= prod_sum_q[PSUM_W-1];
				tmag_q   <= MAG_W'($unsigned(time_sum_q[SUM_W-1] ? -time_sum_q : time_sum_q));
				vmag_q   <= MAG_W'($unsigned(value_sum_q[SUM_W-1] ? -value_sum_q
					: value_sum_q));
				pmag_q   <= MAG_W'($unsigned(prod_sum_q[PSUM_W-1] ? -prod_sum_q : prod_sum_q));
			end
			ST_ACC: begin
				step_q <= step_q + 1'b1;
				if (step_q[1:0] == 2'd3 && prod_idx == 2'd1) begin
					num_q <= acc_nxt;
					acc_q <= '0;
				end else begin
					acc_q <= acc_nxt;
				end
				if (last_step) begin
					den_ok_q <= den_ok_now;
				end
			end
			ST_CAP: begin
				mag_q <= q_over ? cap : q_eff[SLOPE_W-1:0];
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_out) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			slope_q   <= slope_d;
			trend_q   <= trend_d;
			ovf_out_q <= ovf_q;
		end
	end

	rst_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.op   (mul_op),
		.prod (prod)
	);

	rst_div #(
		.WIDTH (ACC_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (acc_nxt),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign sample_stall = (state_q != ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign slope        = slope_q;
	assign trend        = trend_q;
	assign overflowed   = ovf_out_q;

	`RST_ASSERT_IMP(a_out_from_finish, $rose(result_valid), $past(state_q == ST_FINISH),
		"result appeared without a window close")
	`RST_ASSERT_IMP(a_undef_zero, result_valid && (trend == TREND_UNDEF), slope == '0,
		"undefined trend with nonzero slope")
	`RST_ASSERT_IMP(a_empty_window, count_q == '0,
		(time_sum_q == '0) && (value_sum_q == '0) && (prod_sum_q == '0),
		"sums not clear on empty window")
	`RST_ASSERT_IMP(a_div_in_state, div_done, state_q == ST_DIV,
		"divider finished outside the divide state")
	`RST_ASSERT_NXT(a_finish_loads, (state_q == ST_FINISH) && !result_valid, result_valid,
		"free result register not loaded on close")

endmodule
`default_nettype wire

### hw/rtl/rst_mul.sv
// Shared signed multiplier with registered product.
`default_nettype none
module rst_mul import rst_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire mul_op_t                  op,
	output logic signed [PROD_W-1:0]      prod
);

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= op.a * op.b;
		end
	end

	assign prod = prod_q;

endmodule
`default_nettype wire

### hw/rtl/rst_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module rst_div import rst_pkg::*; #(
	parameter int unsigned WIDTH = ACC_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [WIDTH-1:0] dividend,
	input  wire logic [WIDTH-1:0] divisor,
	output logic                  done,
	output logic [WIDTH-1:0]      quotient
);

	localparam int unsigned CNT_W = $clog2(WIDTH + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] dvs_q;
	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic             fits;

	assign trial = {rem_q, quo_q[WIDTH-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = !diff[WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
			quo_q <= {quo_q[WIDTH-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire
